// File: rtl/adsr_pkg.sv
// ============================================================================
// ADSR envelope package
// Shared types, phase codes, register indexes and default widths.
// ============================================================================
package adsr_pkg;

    // default widths
    localparam int PROGRESS_BITS_DEF = 24;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int LEVEL_BITS_DEF    = 16;

    // step register reset value (progress increment per sample)
    localparam int STEP_RESET = 349;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK_STEP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_STEP  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN_LEVEL = 2'd3;

    // envelope phase codes
    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    // sequencer states
    typedef enum logic [2:0] {
        CS_IDLE,
        CS_ENV,
        CS_LVL,
        CS_GAIN,
        CS_OUT
    } core_state_t;

    // per-stage enables from the sequencer
    typedef struct packed {
        logic env_en;   // apply key edge, advance progress, form level product
        logic lvl_en;   // finish level
        logic gain_en;  // lane multiplies
        logic out_ld;   // load output register
    } ctrl_t;

endpackage

// File: rtl/adsr_env_ctrl.sv
// ============================================================================
// ADSR envelope control
// Key edge detection, phase/progress state and level computation.
// ============================================================================
module adsr_env_ctrl import adsr_pkg::*; #(
    parameter int PROGRESS_BITS = PROGRESS_BITS_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ctrl_t                  ctrl_i,
    input  logic                   key_i,
    input  logic [PROGRESS_BITS:0] attack_step_i,
    input  logic [PROGRESS_BITS:0] decay_step_i,
    input  logic [PROGRESS_BITS:0] release_step_i,
    input  logic [LEVEL_BITS:0]    sustain_i,
    output logic [LEVEL_BITS:0]    level_o,
    output phase_t                 phase_o
);

    localparam int PW = PROGRESS_BITS;
    localparam int LW = LEVEL_BITS;
    localparam int MW = PW + LW + 2;
    localparam logic [LW:0] LVL_ONE  = {1'b1, {LW{1'b0}}};
    localparam logic [PW:0] PROG_ONE = {1'b1, {PW{1'b0}}};

    phase_t          phase_reg, phase_next, phase_e;
    logic [PW-1:0]   progress_reg, progress_next, prog_e, prog_adv;
    logic            key_before_reg;
    logic [MW-1:0]   prod_reg, prod_next;
    logic            decay_sel_reg;
    logic [LW:0]     level_reg, level_next, lvl_raw, s_sat;
    logic [PW:0]     step_sel, mul_a;
    logic [LW:0]     mul_b;
    logic [PW+1:0]   sum;
    logic            done;

    assign s_sat = (sustain_i > LVL_ONE) ? LVL_ONE : sustain_i;

    // key edges restart the phase
    always_comb begin
        phase_e = phase_reg;
        prog_e  = progress_reg;
        if (key_i && !key_before_reg) begin
            phase_e = PH_ATTACK;
            prog_e  = '0;
        end else if (!key_i && key_before_reg) begin
            phase_e = PH_RELEASE;
            prog_e  = '0;
        end
    end

    always_comb begin
        case (phase_e)
            PH_ATTACK:  step_sel = attack_step_i;
            PH_DECAY:   step_sel = decay_step_i;
            PH_RELEASE: step_sel = release_step_i;
            default:    step_sel = '0;
        endcase
    end

    assign sum      = (PW+2)'(prog_e) + (PW+2)'(step_sel);
    assign done     = |sum[PW+1:PW];
    assign prog_adv = done ? '0 : sum[PW-1:0];

    // next phase and multiplier operands; product >> PW gives the level
    always_comb begin
        phase_next    = PH_IDLE;
        progress_next = prog_e;
        mul_a         = '0;
        mul_b         = '0;
        case (phase_e)
            PH_ATTACK: begin
                phase_next    = done ? PH_DECAY : PH_ATTACK;
                progress_next = prog_adv;
                mul_a         = {1'b0, prog_adv};
                mul_b         = LVL_ONE;
            end
            PH_DECAY: begin
                phase_next    = done ? PH_SUSTAIN : PH_DECAY;
                progress_next = prog_adv;
                mul_a         = {1'b0, prog_adv};
                mul_b         = LVL_ONE - s_sat;
            end
            PH_SUSTAIN: begin
                phase_next = PH_SUSTAIN;
                mul_a      = PROG_ONE;
                mul_b      = s_sat;
            end
            PH_RELEASE: begin
                phase_next    = done ? PH_IDLE : PH_RELEASE;
                progress_next = prog_adv;
                mul_a         = PROG_ONE - {1'b0, prog_adv};
                mul_b         = s_sat;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign prod_next  = MW'(mul_a) * MW'(mul_b);
    assign lvl_raw    = prod_reg[PW+LW:PW];
    assign level_next = decay_sel_reg ? (LVL_ONE - lvl_raw) : lvl_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            progress_reg   <= '0;
            key_before_reg <= 1'b0;
        end else if (ctrl_i.env_en) begin
            phase_reg      <= phase_next;
            progress_reg   <= progress_next;
            key_before_reg <= key_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.env_en) begin
            prod_reg      <= prod_next;
            decay_sel_reg <= (phase_e == PH_DECAY);
        end
        if (ctrl_i.lvl_en) begin
            level_reg <= level_next;
        end
    end

    assign level_o = level_reg;
    assign phase_o = phase_reg;

endmodule

// File: rtl/adsr_gain_lane.sv
// ============================================================================
// ADSR gain lane
// Scales one signed sample by the envelope level, floor rounding.
// ============================================================================
module adsr_gain_lane import adsr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
    input  logic                          aclk,
    input  ctrl_t                         ctrl_i,
    input  logic signed [SAMPLE_BITS-1:0] sample_i,
    input  logic [LEVEL_BITS:0]           level_i,
    output logic signed [SAMPLE_BITS-1:0] result_o
);

    localparam int PW = SAMPLE_BITS + LEVEL_BITS + 2;

    logic signed [PW-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (ctrl_i.gain_en) begin
            prod_reg <= PW'(sample_i) * PW'($signed({1'b0, level_i}));
        end
    end

    // arithmetic shift right by LEVEL_BITS, keep the sample width
    assign result_o = prod_reg[SAMPLE_BITS+LEVEL_BITS-1:LEVEL_BITS];

endmodule

// File: rtl/adsr_merge.sv
// ============================================================================
// ADSR output merge
// Joins both lanes with level, phase and marker into the output register.
// ============================================================================
module adsr_merge import adsr_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int LEVEL_BITS  = LEVEL_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ctrl_t                         ctrl_i,
    input  logic signed [SAMPLE_BITS-1:0] left_i,
    input  logic signed [SAMPLE_BITS-1:0] right_i,
    input  logic [LEVEL_BITS:0]           level_i,
    input  phase_t                        phase_i,
    input  logic                          buffer_end_i,
    output logic                          out_free_o,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic [LEVEL_BITS:0]           m_envelope_level,
    output logic [2:0]                    m_phase_now,
    output logic                          m_buffer_end_out
);

    logic                          valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;
    logic [LEVEL_BITS:0]           level_reg;
    logic [2:0]                    phase_reg;
    logic                          bend_reg;

    assign out_free_o = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (ctrl_i.out_ld) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl_i.out_ld) begin
            left_reg  <= left_i;
            right_reg <= right_i;
            level_reg <= level_i;
            phase_reg <= phase_i;
            bend_reg  <= buffer_end_i;
        end
    end

    assign m_valid          = valid_reg;
    assign m_left_out       = left_reg;
    assign m_right_out      = right_reg;
    assign m_envelope_level = level_reg;
    assign m_phase_now      = phase_reg;
    assign m_buffer_end_out = bend_reg;

endmodule

// File: rtl/adsr_envelope_stereo_gain_unit.sv
// ============================================================================
// ADSR envelope stereo gain unit
// Linear attack/decay/sustain/release envelope applied to a stereo stream.
// ============================================================================
// Usage:
//   Input channel (s_*): one transaction per sample pair, carrying the key
//   level, the left/right samples and a buffer-end marker. A key rising edge
//   starts attack, a falling edge starts release.
//   Output channel (m_*): one transaction per input pair with the scaled
//   samples, the Q(LEVEL_BITS) gain applied and the phase after the step.
//   Config port: cfg_wr_en/cfg_wr_index/cfg_wr_data write attack, decay and
//   release steps and the sustain level, one register per write; write only when idle.
// Timing:
//   A pair runs through four steps of a sequencer: envelope update with the
//   level multiply, level finish, the two lane multiplies, output load.
//   m_valid is registered and rises after the output load step. The next pair
//   is taken in the cycle the output register loads, so a new pair is accepted
//   only once the previous one has been loaded out.
// Reset (aresetn, synchronous, active low): phase idle, progress zero, key
//   released, registers to defaults, no output pending.
// Stall: a held output register keeps the sequencer in its load step and
//   s_ready low until m_ready frees it; nothing is dropped.
// ============================================================================
module adsr_envelope_stereo_gain_unit import adsr_pkg::*; #(
    parameter int PROGRESS_BITS = PROGRESS_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int LEVEL_BITS    = LEVEL_BITS_DEF,
    localparam int CFG_W = (PROGRESS_BITS > LEVEL_BITS) ? PROGRESS_BITS + 1 : LEVEL_BITS + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_wr_index,
    input  logic [CFG_W-1:0]              cfg_wr_data,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_key_pressed,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    input  logic                          s_buffer_end,
    // output channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic [LEVEL_BITS:0]           m_envelope_level,
    output logic [2:0]                    m_phase_now,
    output logic                          m_buffer_end_out
);

    localparam logic [PROGRESS_BITS:0] STEP_RST = (PROGRESS_BITS+1)'(STEP_RESET);
    localparam logic [LEVEL_BITS:0]    SUS_RST  = {2'b01, {(LEVEL_BITS-1){1'b0}}};

    // configuration registers
    logic [PROGRESS_BITS:0] attack_step_reg, decay_step_reg, release_step_reg;
    logic [LEVEL_BITS:0]    sustain_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attack_step_reg  <= STEP_RST;
            decay_step_reg   <= STEP_RST;
            release_step_reg <= STEP_RST;
            sustain_reg      <= SUS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ATTACK_STEP:   attack_step_reg  <= cfg_wr_data[PROGRESS_BITS:0];
                CFG_DECAY_STEP:    decay_step_reg   <= cfg_wr_data[PROGRESS_BITS:0];
                CFG_RELEASE_STEP:  release_step_reg <= cfg_wr_data[PROGRESS_BITS:0];
                CFG_SUSTAIN_LEVEL: sustain_reg      <= cfg_wr_data[LEVEL_BITS:0];
                default: ;
            endcase
        end
    end

    // sequencer
    core_state_t state_reg, state_next;
    ctrl_t       ctrl;
    logic        out_free;
    logic        s_accept;

    assign s_accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: if (s_valid) state_next = CS_ENV;
            CS_ENV:  state_next = CS_LVL;
            CS_LVL:  state_next = CS_GAIN;
            CS_GAIN: state_next = CS_OUT;
            CS_OUT: begin
                if (out_free) state_next = s_valid ? CS_ENV : CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        ctrl    = '0;
        s_ready = 1'b0;
        case (state_reg)
            CS_IDLE: s_ready = 1'b1;
            CS_ENV:  ctrl.env_en = 1'b1;
            CS_LVL:  ctrl.lvl_en = 1'b1;
            CS_GAIN: ctrl.gain_en = 1'b1;
            CS_OUT: begin
                ctrl.out_ld = out_free;
                s_ready     = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // input holding register for the pair in flight
    logic                          key_reg, bend_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg, right_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg   <= s_key_pressed;
            left_reg  <= s_left_sample;
            right_reg <= s_right_sample;
            bend_reg  <= s_buffer_end;
        end
    end

    // envelope
    logic [LEVEL_BITS:0] level;
    phase_t              phase;

    adsr_env_ctrl #(
        .PROGRESS_BITS (PROGRESS_BITS),
        .LEVEL_BITS    (LEVEL_BITS)
    ) u_env (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl_i         (ctrl),
        .key_i          (key_reg),
        .attack_step_i  (attack_step_reg),
        .decay_step_i   (decay_step_reg),
        .release_step_i (release_step_reg),
        .sustain_i      (sustain_reg),
        .level_o        (level),
        .phase_o        (phase)
    );

    // gain lanes, one per channel
    logic signed [SAMPLE_BITS-1:0] left_scaled, right_scaled;

    adsr_gain_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_lane_left (
        .aclk     (aclk),
        .ctrl_i   (ctrl),
        .sample_i (left_reg),
        .level_i  (level),
        .result_o (left_scaled)
    );

    adsr_gain_lane #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_lane_right (
        .aclk     (aclk),
        .ctrl_i   (ctrl),
        .sample_i (right_reg),
        .level_i  (level),
        .result_o (right_scaled)
    );

    // output register
    adsr_merge #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .LEVEL_BITS  (LEVEL_BITS)
    ) u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl_i           (ctrl),
        .left_i           (left_scaled),
        .right_i          (right_scaled),
        .level_i          (level),
        .phase_i          (phase),
        .buffer_end_i     (bend_reg),
        .out_free_o       (out_free),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_out       (m_left_out),
        .m_right_out      (m_right_out),
        .m_envelope_level (m_envelope_level),
        .m_phase_now      (m_phase_now),
        .m_buffer_end_out (m_buffer_end_out)
    );

`ifndef SYNTH
    // an accepted pair always makes the sequencer busy next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous pair in flight");

    // gain never exceeds unity
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_envelope_level <= {1'b1, {LEVEL_BITS{1'b0}}}))
        else $error("envelope level above unity");

    // a new result only appears out of the load step
    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == CS_OUT))
        else $error("output valid without load step");
`endif

endmodule

// File: tb/sv/adsr_envelope_stereo_gain_checker.sv
// ============================================================================
// ADSR envelope stereo gain checker
// Watches the config port and both channels, keeps its own envelope model and
// compares every output transaction against the oldest predicted pair.
// ============================================================================
module adsr_envelope_stereo_gain_checker import adsr_pkg::*; #(
    parameter int PB = PROGRESS_BITS_DEF,
    parameter int SB = SAMPLE_BITS_DEF,
    parameter int LB = LEVEL_BITS_DEF,
    parameter int CW = (PROGRESS_BITS_DEF > LEVEL_BITS_DEF) ? PROGRESS_BITS_DEF + 1
                                                           : LEVEL_BITS_DEF + 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CW-1:0]        cfg_wr_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 s_key_pressed,
    input  logic signed [SB-1:0] s_left_sample,
    input  logic signed [SB-1:0] s_right_sample,
    input  logic                 s_buffer_end,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic signed [SB-1:0] m_left_out,
    input  logic signed [SB-1:0] m_right_out,
    input  logic [LB:0]          m_envelope_level,
    input  logic [2:0]           m_phase_now,
    input  logic                 m_buffer_end_out,
    output int                   mismatches,
    output int                   outstanding,
    output int                   pairs_checked,
    output logic [4:0]           phases_seen
);

    localparam longint unsigned LVL_ONE  = 64'd1 << LB;
    localparam longint unsigned PROG_ONE = 64'd1 << PB;

    typedef struct {
        logic signed [SB-1:0] left;
        logic signed [SB-1:0] right;
        logic [LB:0]          level;
        phase_t               ph;
        logic                 marker;
    } pair_result_t;

    // register mirror
    logic [PB:0] attack_step_r;
    logic [PB:0] decay_step_r;
    logic [PB:0] release_step_r;
    logic [LB:0] sustain_r;

    // envelope state
    phase_t        env_phase;
    logic [PB-1:0] progress;
    logic          key_q;

    pair_result_t  pending_q[$];

    initial begin
        mismatches    = 0;
        pairs_checked = 0;
        phases_seen   = '0;
        outstanding   = 0;
    end

    // add one step; on reaching unity progress wraps to zero and the phase ends
    function automatic bit phase_complete(input logic [PB:0] stp);
        logic [PB+1:0] sum;
        sum = progress + stp;
        if (sum >= PROG_ONE) begin
            progress = '0;
            return 1'b1;
        end
        progress = sum[PB-1:0];
        return 1'b0;
    endfunction

    // floor(x * level / ONE): arithmetic shift of the signed product
    function automatic logic signed [SB-1:0] apply_level(input logic signed [SB-1:0] x,
                                                         input logic [LB:0] lvl);
        longint prod;
        longint gain;
        gain = lvl;
        prod = x;
        prod = (prod * gain) >>> LB;
        return prod[SB-1:0];
    endfunction

    function automatic pair_result_t envelope_step(input logic key,
                                                   input logic signed [SB-1:0] left,
                                                   input logic signed [SB-1:0] right,
                                                   input logic marker);
        longint unsigned sus;
        longint unsigned prog;
        longint unsigned lvl;
        pair_result_t    res;
        sus = (sustain_r > LVL_ONE) ? LVL_ONE : sustain_r;   // saturate at unity
        if (key && !key_q) begin
            env_phase = PH_ATTACK;
            progress  = '0;
        end else if (!key && key_q) begin
            env_phase = PH_RELEASE;
            progress  = '0;
        end
        key_q = key;
        case (env_phase)
            PH_ATTACK: begin
                if (phase_complete(attack_step_r)) env_phase = PH_DECAY;
                prog = progress;
                lvl  = (prog << LB) >> PB;
            end
            PH_DECAY: begin
                if (phase_complete(decay_step_r)) env_phase = PH_SUSTAIN;
                prog = progress;
                lvl  = LVL_ONE - ((prog * (LVL_ONE - sus)) >> PB);
            end
            PH_SUSTAIN: begin
                lvl = sus;
            end
            PH_RELEASE: begin
                if (phase_complete(release_step_r)) env_phase = PH_IDLE;
                prog = progress;
                lvl  = ((PROG_ONE - prog) * sus) >> PB;
            end
            default: begin
                env_phase = PH_IDLE;
                lvl       = 0;
            end
        endcase
        res.level  = lvl[LB:0];
        res.left   = apply_level(left, res.level);
        res.right  = apply_level(right, res.level);
        res.ph     = env_phase;
        res.marker = marker;
        return res;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        pair_result_t want;
        if (!aresetn) begin
            attack_step_r  = STEP_RESET;
            decay_step_r   = STEP_RESET;
            release_step_r = STEP_RESET;
            sustain_r      = 1 << (LB - 1);
            env_phase      = PH_IDLE;
            progress       = '0;
            key_q          = 1'b0;
            pending_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_ATTACK_STEP:   attack_step_r  = cfg_wr_data[PB:0];
                    CFG_DECAY_STEP:    decay_step_r   = cfg_wr_data[PB:0];
                    CFG_RELEASE_STEP:  release_step_r = cfg_wr_data[PB:0];
                    CFG_SUSTAIN_LEVEL: sustain_r      = cfg_wr_data[LB:0];
                    default: ;
                endcase
            end
            // output first: a pair accepted on this edge cannot already be out
            if (m_valid && m_ready) begin
                if (pending_q.size() == 0) begin
                    $display("%0t: output transaction with no pair pending", $time);
                    mismatches++;
                end else begin
                    want = pending_q.pop_front();
                    check_field("left_out", want.left, m_left_out);
                    check_field("right_out", want.right, m_right_out);
                    check_field("envelope_level", want.level, m_envelope_level);
                    check_field("phase_now", want.ph, m_phase_now);
                    check_field("buffer_end_out", want.marker, m_buffer_end_out);
                    phases_seen[want.ph] = 1'b1;
                    pairs_checked++;
                end
            end
            if (s_valid && s_ready)
                pending_q.push_back(envelope_step(s_key_pressed, s_left_sample,
                                                  s_right_sample, s_buffer_end));
        end
        outstanding <= pending_q.size();
    end

endmodule

// File: tb/sv/tb_adsr_envelope_stereo_gain_unit.sv
// ============================================================================
// ADSR envelope stereo gain unit testbench
// Directed pairs at reset defaults and at edge-case register settings, then
// key press/release sequences with random samples over several settings.
// Sender runs in bursts, receiver stalls on its own pattern; the checker
// instance predicts and compares every output transaction.
// ============================================================================
module tb_adsr_envelope_stereo_gain_unit;
    import adsr_pkg::*;

    localparam int CFG_W = (PROGRESS_BITS_DEF > LEVEL_BITS_DEF) ? PROGRESS_BITS_DEF + 1
                                                              : LEVEL_BITS_DEF + 1;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 8;       // settle margin past the unit's latency
    localparam int LONG_HOLD     = 300;     // receiver back-pressure window
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 8;
    localparam int PAIRS_PER_PHASE = 150;

    localparam logic [SAMPLE_BITS_DEF-1:0] SMP_MIN = 16'h8000;
    localparam logic [SAMPLE_BITS_DEF-1:0] SMP_MAX = 16'h7FFF;
    localparam logic [SAMPLE_BITS_DEF-1:0] SMP_NEG1 = 16'hFFFF;
    localparam logic [SAMPLE_BITS_DEF-1:0] SMP_ONE = 16'h0001;
    localparam logic [SAMPLE_BITS_DEF-1:0] SMP_ZERO = 16'h0000;

    // step values: unity progress means the phase ends on its first sample
    localparam logic [CFG_W-1:0] STEP_UNITY = 1 << PROGRESS_BITS_DEF;
    localparam logic [CFG_W-1:0] STEP_HALF  = 1 << (PROGRESS_BITS_DEF - 1);
    localparam logic [CFG_W-1:0] STEP_MAX   = '1;
    localparam logic [CFG_W-1:0] LEVEL_UNITY = 1 << LEVEL_BITS_DEF;

    // ------------------------------------------------------------------------
    // clock, reset, DUT inputs (all known from time zero)
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_wr_index = CFG_ATTACK_STEP;
    logic [CFG_W-1:0]            cfg_wr_data  = '0;

    logic                        s_valid        = 1'b0;
    logic                        s_ready;
    logic                        s_key_pressed  = 1'b0;
    logic signed [SAMPLE_BITS_DEF-1:0] s_left_sample  = '0;
    logic signed [SAMPLE_BITS_DEF-1:0] s_right_sample = '0;
    logic                        s_buffer_end   = 1'b0;

    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [SAMPLE_BITS_DEF-1:0] m_left_out;
    logic signed [SAMPLE_BITS_DEF-1:0] m_right_out;
    logic [LEVEL_BITS_DEF:0]     m_envelope_level;
    logic [2:0]                  m_phase_now;
    logic                        m_buffer_end_out;

    int         chk_mismatches;
    int         chk_outstanding;
    int         chk_pairs_checked;
    logic [4:0] chk_phases_seen;

    int cycle_count      = 0;
    int pairs_sent       = 0;
    int directed_pairs   = 0;
    int settings_applied = 0;
    int long_stalls      = 0;
    int burst_left       = 0;
    bit hold_req         = 1'b0;   // asks the receiver for one long hold-off

    always #1 aclk = ~aclk;

    adsr_envelope_stereo_gain_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_pressed    (s_key_pressed),
        .s_left_sample    (s_left_sample),
        .s_right_sample   (s_right_sample),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_out       (m_left_out),
        .m_right_out      (m_right_out),
        .m_envelope_level (m_envelope_level),
        .m_phase_now      (m_phase_now),
        .m_buffer_end_out (m_buffer_end_out)
    );

    adsr_envelope_stereo_gain_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_key_pressed    (s_key_pressed),
        .s_left_sample    (s_left_sample),
        .s_right_sample   (s_right_sample),
        .s_buffer_end     (s_buffer_end),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_left_out       (m_left_out),
        .m_right_out      (m_right_out),
        .m_envelope_level (m_envelope_level),
        .m_phase_now      (m_phase_now),
        .m_buffer_end_out (m_buffer_end_out),
        .mismatches       (chk_mismatches),
        .outstanding      (chk_outstanding),
        .pairs_checked    (chk_pairs_checked),
        .phases_seen      (chk_phases_seen)
    );

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d pairs still pending",
                     $time, cycle_count, chk_outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // receiver: stretches of always-ready, coin-flip, one-in-four and mostly
    // ready; a pending hold request turns into one long back-pressure window
    // so the unit fills up and drops s_ready while the sender keeps offering
    // ------------------------------------------------------------------------
    initial begin : output_stall_pattern
        int mode;
        int span;
        int k;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                for (k = 0; k < LONG_HOLD; k++) @(posedge aclk);
                hold_req = 1'b0;
                long_stalls++;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 80);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0:       m_ready <= 1'b1;
                        1:       m_ready <= $urandom_range(0, 1);
                        2:       m_ready <= (k % 4 == 0);
                        default: m_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender helpers
    // ------------------------------------------------------------------------

    // bursts of back-to-back transactions separated by short random gaps
    function automatic int next_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(0, 24);
        return $urandom_range(1, 9);
    endfunction

    // Offer one pair and wait for the handshake. With no gap, valid stays up and
    // the caller must offer the next pair (or drain) in this same time step.
    task automatic send_pair(input logic key, input logic [SAMPLE_BITS_DEF-1:0] left,
                             input logic [SAMPLE_BITS_DEF-1:0] right, input logic marker);
        int gap;
        gap = next_gap();
        s_valid        <= 1'b1;
        s_key_pressed  <= key;
        s_left_sample  <= left;
        s_right_sample <= right;
        s_buffer_end   <= marker;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pairs_sent++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // stop offering, wait until every predicted pair has come out, then settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chk_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // one write per cycle; enable drops only after the last one
    task automatic apply_settings(input logic [CFG_W-1:0] attack, input logic [CFG_W-1:0] decay,
                                  input logic [CFG_W-1:0] release_v,
                                  input logic [CFG_W-1:0] sustain);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_ATTACK_STEP;
        cfg_wr_data  <= attack;
        @(posedge aclk);
        cfg_wr_index <= CFG_DECAY_STEP;
        cfg_wr_data  <= decay;
        @(posedge aclk);
        cfg_wr_index <= CFG_RELEASE_STEP;
        cfg_wr_data  <= release_v;
        @(posedge aclk);
        cfg_wr_index <= CFG_SUSTAIN_LEVEL;
        cfg_wr_data  <= sustain;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return SMP_MIN;
            1:       return SMP_MAX;
            2:       return SMP_NEG1;
            3:       return SMP_ONE;
            default: return $urandom;
        endcase
    endfunction

    // mostly steps that finish a phase within a few dozen pairs,
    // some slow ones and some that end the phase at once
    function automatic logic [CFG_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 4096);
            1:       return $urandom_range(STEP_UNITY, STEP_MAX);
            default: return $urandom_range(1 << 19, STEP_HALF);
        endcase
    endfunction

    // sustain in the low bits, random junk above the register width
    function automatic logic [CFG_W-1:0] pick_sustain();
        logic [CFG_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 7))
            0:       v[LEVEL_BITS_DEF:0] = '0;
            1:       v[LEVEL_BITS_DEF:0] = LEVEL_UNITY;
            2:       v[LEVEL_BITS_DEF:0] = $urandom_range(LEVEL_UNITY + 1, (2 << LEVEL_BITS_DEF) - 1);
            default: v[LEVEL_BITS_DEF:0] = $urandom_range(0, LEVEL_UNITY);
        endcase
        return v;
    endfunction

    // Key held for a while then released, with random samples. About one
    // segment in seven is key chatter: a fresh random key level on every pair.
    task automatic run_key_sequences(input int count);
        int done_cnt;
        int seg;
        int k;
        done_cnt = 0;
        while (done_cnt < count) begin
            if ($urandom_range(0, 6) == 0) begin
                seg = $urandom_range(1, 12);
                for (k = 0; k < seg; k++) begin
                    send_pair($urandom_range(0, 1), pick_sample(), pick_sample(),
                              $urandom_range(0, 7) == 0);
                    done_cnt++;
                end
            end else begin
                seg = $urandom_range(1, 80);
                for (k = 0; k < seg; k++) begin
                    send_pair(1'b1, pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
                    done_cnt++;
                end
                seg = $urandom_range(1, 40);
                for (k = 0; k < seg; k++) begin
                    send_pair(1'b0, pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
                    done_cnt++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int ph;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: idle pair, attack start with slow steps, release
        send_pair(1'b0, SMP_ZERO, SMP_ZERO, 1'b0);
        send_pair(1'b1, SMP_MAX, SMP_MIN, 1'b1);
        send_pair(1'b1, SMP_MIN, SMP_MAX, 1'b0);
        send_pair(1'b0, SMP_NEG1, SMP_ONE, 1'b0);
        send_pair(1'b0, SMP_ONE, SMP_NEG1, 1'b1);
        wait_idle();

        // instant attack, two-pair decay, widest release step, sustain
        // written above unity with all upper data bits set (saturates)
        apply_settings(STEP_UNITY, STEP_HALF, STEP_MAX, '1);
        send_pair(1'b0, SMP_MAX, SMP_MAX, 1'b0);
        send_pair(1'b1, SMP_MAX, SMP_MAX, 1'b0);
        send_pair(1'b1, SMP_MIN, SMP_MIN, 1'b1);
        send_pair(1'b1, SMP_MIN, SMP_MAX, 1'b0);
        send_pair(1'b1, SMP_MAX, SMP_MIN, 1'b0);
        send_pair(1'b0, SMP_MIN, SMP_NEG1, 1'b0);
        send_pair(1'b0, SMP_MAX, SMP_ONE, 1'b1);
        send_pair(1'b1, SMP_NEG1, SMP_MIN, 1'b0);
        send_pair(1'b0, SMP_ONE, SMP_MAX, 1'b0);
        wait_idle();

        // zero attack step holds attack at level zero; release step of
        // exactly unity finishes on the first pair; sustain zero
        apply_settings('0, STEP_UNITY - 1, STEP_UNITY, '0);
        send_pair(1'b1, SMP_MAX, SMP_MIN, 1'b0);
        send_pair(1'b1, SMP_MIN, SMP_MAX, 1'b1);
        send_pair(1'b1, SMP_NEG1, SMP_ONE, 1'b0);
        send_pair(1'b0, SMP_MAX, SMP_MAX, 1'b0);
        send_pair(1'b0, SMP_MIN, SMP_MIN, 1'b0);
        wait_idle();

        // two-pair attack, zero decay step (decay holds), slowest release
        apply_settings(STEP_HALF, '0, 1, 1 << (LEVEL_BITS_DEF - 2));
        send_pair(1'b1, SMP_MAX, SMP_MIN, 1'b0);
        send_pair(1'b1, SMP_MAX, SMP_MIN, 1'b0);
        send_pair(1'b1, SMP_MIN, SMP_MAX, 1'b1);
        send_pair(1'b1, SMP_NEG1, SMP_MAX, 1'b0);
        send_pair(1'b0, SMP_MAX, SMP_MIN, 1'b0);
        send_pair(1'b0, SMP_MIN, SMP_NEG1, 1'b1);
        directed_pairs = pairs_sent;

        // random part: first and last settings are the register extremes
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            if (ph == 0)
                apply_settings(1, 1, 1, pick_sustain() & ~LEVEL_UNITY & ~(LEVEL_UNITY - 1));
            else if (ph == RANDOM_PHASES - 1)
                apply_settings(STEP_MAX, STEP_MAX, STEP_MAX, LEVEL_UNITY);
            else
                apply_settings(pick_step(), pick_step(), pick_step(), pick_sustain());
            if (ph == 2 || ph == 5)
                hold_req = 1'b1;
            run_key_sequences(PAIRS_PER_PHASE);
        end
        wait_idle();

        $display("Run: %0d pairs sent (%0d directed), %0d checked, %0d register settings",
                 pairs_sent, directed_pairs, chk_pairs_checked, settings_applied);
        $display("Envelope phases seen (release..idle): %b, long output stalls: %0d",
                 chk_phases_seen, long_stalls);
        if (chk_mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
